// ===== rtl/dss_pkg.sv =====
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants for the disk seek scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package dss_pkg;
  localparam int MaxRequests = 32;
  localparam int IdxW = $clog2(MaxRequests);
  localparam int CntW = $clog2(MaxRequests + 1);
  localparam int TrackW = 16;
  localparam int SumW = 22;
  localparam int KeyW = TrackW + 1;

  localparam logic [1:0] POL_FCFS  = 2'd0;
  localparam logic [1:0] POL_SSTF  = 2'd1;
  localparam logic [1:0] POL_SCAN  = 2'd2;
  localparam logic [1:0] POL_CSCAN = 2'd3;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_START  = 2'd1;
  localparam logic [1:0] REG_SWEEP  = 2'd2;

  typedef struct packed {
    logic            store;
    logic            start_batch;
    logic            sel_clear;
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            emit;
    logic            last;
    logic            done;
  } cmd_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic            out_busy;
  } stat_t;
endpackage
`default_nettype wire

// ===== rtl/dss_datapath.sv =====
// ----------------------------------------------------------------------------
// dss_datapath
// Request store, served marks, selection compare and output register.
// ----------------------------------------------------------------------------
`default_nettype none
module dss_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire dss_pkg::cmd_t              cmd,
  output dss_pkg::stat_t                  stat,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [15:0]                cfg_data,
  input  wire logic [15:0]                request_track,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [15:0]                     served_track,
  output logic [15:0]                     seek_distance,
  output logic [21:0]                     total_distance,
  output logic                            overflow,
  output logic                            last_served
);
  logic [15:0] mem [dss_pkg::MaxRequests];
  logic [15:0] mem_q;
  logic [dss_pkg::MaxRequests-1:0] mark;
  logic [dss_pkg::CntW-1:0] count;
  logic dropped;
  logic [1:0] policy;
  logic [15:0] start_track;
  logic sweep;
  logic [15:0] pos;
  logic [21:0] sum;
  logic rd_valid;
  logic [dss_pkg::IdxW-1:0] rd_idx;
  logic found;
  logic [dss_pkg::KeyW-1:0] best_key;
  logic [dss_pkg::IdxW-1:0] best_idx;
  logic [15:0] best_track;
  logic [dss_pkg::KeyW-1:0] key;
  logic [15:0] gap_pos, gap_best;

  assign gap_pos  = (pos > mem_q) ? pos - mem_q : mem_q - pos;
  assign gap_best = (pos > best_track) ? pos - best_track : best_track - pos;

  always_comb begin
    key = '0;
    case (policy)
      dss_pkg::POL_FCFS: key = '0;
      dss_pkg::POL_SSTF: key = {1'b0, gap_pos};
      default: begin
        if (!sweep) begin
          if (mem_q <= start_track) key = {1'b0, ~mem_q};
          else if (policy == dss_pkg::POL_SCAN) key = {1'b1, mem_q};
          else key = {1'b1, ~mem_q};
        end else begin
          if (mem_q >= start_track) key = {1'b0, mem_q};
          else if (policy == dss_pkg::POL_SCAN) key = {1'b1, ~mem_q};
          else key = {1'b1, mem_q};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.store && count < dss_pkg::CntW'(dss_pkg::MaxRequests))
      mem[count[dss_pkg::IdxW-1:0]] <= request_track;
    if (cmd.rd_en) mem_q <= mem[cmd.rd_addr];
    rd_idx <= cmd.rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= dss_pkg::POL_FCFS;
      start_track <= '0;
      sweep <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        dss_pkg::REG_POLICY: policy <= cfg_data[1:0];
        dss_pkg::REG_START:  start_track <= cfg_data;
        dss_pkg::REG_SWEEP:  sweep <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      dropped <= 1'b0;
      mark <= '0;
      rd_valid <= 1'b0;
      found <= 1'b0;
      out_valid <= 1'b0;
      pos <= '0;
      sum <= '0;
    end else begin
      rd_valid <= cmd.rd_en;
      if (cmd.store) begin
        if (count < dss_pkg::CntW'(dss_pkg::MaxRequests)) count <= count + 1'b1;
        else dropped <= 1'b1;
      end
      if (cmd.start_batch) begin
        mark <= '0;
        pos <= start_track;
        sum <= '0;
      end
      if (cmd.sel_clear) found <= 1'b0;
      else if (rd_valid && !mark[rd_idx] && (!found || key < best_key)) begin
        found <= 1'b1;
        best_key <= key;
        best_idx <= rd_idx;
        best_track <= mem_q;
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.emit) begin
        out_valid <= 1'b1;
        served_track <= best_track;
        seek_distance <= gap_best;
        total_distance <= sum + 22'(gap_best);
        overflow <= dropped;
        last_served <= cmd.last;
        sum <= sum + 22'(gap_best);
        pos <= best_track;
        mark[best_idx] <= 1'b1;
      end
      if (cmd.done) begin
        count <= '0;
        dropped <= 1'b0;
      end
    end
  end

  assign stat.count = count;
  assign stat.out_busy = out_valid && out_stall;
endmodule
`default_nettype wire

// ===== rtl/dss_ctrl.sv =====
// ----------------------------------------------------------------------------
// dss_ctrl
// Sequencer: collects a batch, then runs one store pass per served word.
// ----------------------------------------------------------------------------
`default_nettype none
module dss_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic           batch_end,
  input  wire dss_pkg::stat_t stat,
  output dss_pkg::cmd_t       cmd
);
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0] state, state_next;
  logic [dss_pkg::CntW-1:0] j, j_next, k, k_next;
  logic accept;

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    state_next = state;
    j_next = j;
    k_next = k;
    cmd.rd_addr = j[dss_pkg::IdxW-1:0];
    cmd.last = (k + 1'b1 == stat.count);
    case (state)
      S_IDLE: begin
        cmd.store = accept;
        if (accept && batch_end) begin
          cmd.start_batch = 1'b1;
          cmd.sel_clear = 1'b1;
          j_next = '0;
          k_next = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        j_next = j + 1'b1;
        if (j + 1'b1 == stat.count) state_next = S_FLUSH;
      end
      S_FLUSH: state_next = S_EMIT;
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit = 1'b1;
          cmd.sel_clear = 1'b1;
          k_next = k + 1'b1;
          j_next = '0;
          if (cmd.last) begin
            cmd.done = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      j <= '0;
      k <= '0;
    end else begin
      state <= state_next;
      j <= j_next;
      k <= k_next;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !stat.out_busy) else $error("emit into busy output");
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (j < stat.count)) else $error("scan past count");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.done |=> (state == S_IDLE && stat.count == '0)) else $error("batch not cleared");
endmodule
`default_nettype wire

// ===== rtl/disk_seek_scheduler.sv =====
// ----------------------------------------------------------------------------
// disk_seek_scheduler
// Collects a batch of track requests, then emits them in service order.
// ----------------------------------------------------------------------------
// Input: one request word per cycle while collecting; stalled while serving.
// Serving: each result takes one pass over the request store for a batch of n
//   requests (one pass per served word), followed by a flush and an emit step.
// Output waits in a register; the next pass runs meanwhile, its emit waits until it is taken.
// Reset (rst, synchronous): store empty, configuration registers zero, no output pending.
`default_nettype none
module disk_seek_scheduler (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] request_track,
  input  wire logic        batch_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      served_track,
  output logic [15:0]      seek_distance,
  output logic [21:0]      total_distance,
  output logic             overflow,
  output logic             last_served
);
  dss_pkg::cmd_t  cmd;
  dss_pkg::stat_t stat;

  dss_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .batch_end, .stat, .cmd
  );

  dss_datapath u_dp (
    .clk, .rst, .cmd, .stat, .cfg_we, .cfg_index, .cfg_data, .request_track,
    .out_valid, .out_stall, .served_track, .seek_distance, .total_distance,
    .overflow, .last_served
  );
endmodule
`default_nettype wire
